>>> rtl/core/ipv4fc_pkg.sv
// shared types, constants and the ones'-complement adder for the ipv4 frame checksum
`timescale 1ns / 1ps

package ipv4fc_pkg;

   localparam logic [15:0] IpHeaderBytes = 16'd20;
   localparam logic [15:0] AddrOffset    = 16'd12;
   localparam logic [15:0] LenLowOffset  = 16'd3;
   localparam logic [15:0] PosMax        = 16'hFFFF;
   localparam logic [15:0] ZeroSumCode   = 16'hFFFF;
   localparam logic [7:0]  ProtocolReset = 8'd17;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } step_type;

   typedef struct packed {
      logic        length_bad;
      logic        frame_short;
      logic [15:0] upper_layer_sum;
      logic [15:0] ip_header_sum;
   } result_type;

   // 16-bit add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

>>> rtl/core/ipv4_frame_checksum.sv
// top level of the ipv4 frame checksum: input register, accumulator and result register
`timescale 1ns / 1ps

// Checks the IPv4 header and upper-layer (pseudo-header plus segment) ones'-complement sums of an
// Ethernet frame fed one byte per transaction, with req_tlast on the final byte. One result
// transaction comes out per frame, once its last byte has passed the input and result registers.
// The block takes one byte every cycle; the only stall is a last byte arriving while the previous
// result is still waiting in the output register and rsp_tready is low. All per-byte work is one
// 16-bit end-around-carry add per accumulator, between the input register and the result register.
module ipv4_frame_checksum
   import ipv4fc_pkg::*;
#(
   parameter int LINK_HEADER_BYTES = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // protocol_number
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // frame_byte
   input  logic        req_tlast,     // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // ip_header_sum [15:0], upper_layer_sum [31:16]
   output logic [1:0]  rsp_tuser      // frame_short [0], length_bad [1]
);

   logic       in_valid_ff, in_valid_in;
   step_type   in_step_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   logic       advance;
   logic       res_valid;
   result_type res;

   // a non-last byte never produces a result, so only a last byte waits on the output
   assign advance    = in_valid_ff && (!in_step_ff.frame_end || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = res_valid || (out_valid_ff && !rsp_tready);

   ipv4fc_accum #(
      .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .step_en    (advance),
      .step       (in_step_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_step_ff.frame_byte <= req_tdata;
         in_step_ff.frame_end  <= req_tlast;
      end
      if (res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_res_ff.upper_layer_sum, out_res_ff.ip_header_sum};
   assign rsp_tuser  = {out_res_ff.length_bad, out_res_ff.frame_short};

   a_no_take_when_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_tready)
      else $error("input register overwritten while holding a transaction");

   a_result_has_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !out_valid_ff || rsp_tready)
      else $error("result register overwritten before it was taken");

   a_body_never_stalls: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_step_ff.frame_end |-> advance)
      else $error("non-last byte stalled");

endmodule

>>> rtl/core/ipv4fc_accum.sv
// per-frame byte position tracking and the two checksum accumulators
`timescale 1ns / 1ps

module ipv4fc_accum
   import ipv4fc_pkg::*;
#(
   parameter int LINK_HEADER_BYTES = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       step_en,
   input  step_type   step,
   output logic       res_valid,
   output result_type res
);

   localparam logic [15:0] LinkBytes = 16'(LINK_HEADER_BYTES);
   localparam logic [16:0] NeedBase  = 17'(LINK_HEADER_BYTES) + {1'b0, IpHeaderBytes};

   logic [7:0]  proto_ff;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] ip_ff, ip_in;
   logic [15:0] upper_ff, upper_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] seg_ff, seg_in;
   logic        known_ff, known_in;
   logic        low_ff, low_in;

   logic [15:0] r;
   logic [15:0] r_seg;
   logic [15:0] w;
   logic        in_range;
   logic        upper_add;
   logic [15:0] upper_addend;
   logic [16:0] have;
   logic [16:0] need;
   logic [15:0] len_term;
   logic [15:0] up_sum;

   always_comb begin
      r            = pos_ff - LinkBytes;
      r_seg        = r - IpHeaderBytes;
      w            = {held_ff, step.frame_byte};
      in_range     = (pos_ff != PosMax) && (pos_ff >= LinkBytes);
      ip_in        = ip_ff;
      held_in      = held_ff;
      seg_in       = seg_ff;
      known_in     = known_ff;
      low_in       = low_ff;
      upper_add    = 1'b0;
      upper_addend = w;
      if (in_range) begin
         if (!r[0]) begin
            held_in = step.frame_byte;
            // odd final segment byte, padded with a zero low byte
            if (known_ff && r >= IpHeaderBytes && seg_ff != 16'd0 &&
                r_seg == seg_ff - 16'd1) begin
               upper_add    = 1'b1;
               upper_addend = {step.frame_byte, 8'h00};
            end
         end else if (r < IpHeaderBytes) begin
            ip_in     = oc_add(ip_ff, w);
            upper_add = (r >= AddrOffset);
            if (r == LenLowOffset) begin
               known_in = 1'b1;
               low_in   = (w < IpHeaderBytes);
               seg_in   = low_in ? 16'd0 : w - IpHeaderBytes;
            end
         end else begin
            upper_add = known_ff && (r_seg < seg_ff);
         end
      end
      upper_in = upper_add ? oc_add(upper_ff, upper_addend) : upper_ff;
      pos_in   = (pos_ff != PosMax) ? pos_ff + 16'd1 : pos_ff;

      have     = (pos_ff == PosMax) ? {1'b0, PosMax} : {1'b0, pos_ff} + 17'd1;
      need     = NeedBase + {1'b0, seg_in};
      len_term = oc_add(seg_in, {8'd0, proto_ff});
      up_sum   = oc_add(upper_in, len_term);

      res_valid           = step_en && step.frame_end;
      res.ip_header_sum   = (ip_in == 16'd0) ? ZeroSumCode : ip_in;
      res.upper_layer_sum = (up_sum == 16'd0) ? ZeroSumCode : up_sum;
      res.frame_short     = !known_in || (have < need);
      res.length_bad      = low_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff <= ProtocolReset;
      end else if (csr_wr_en) begin
         proto_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && step.frame_end)) begin
         pos_ff   <= 16'd0;
         ip_ff    <= 16'd0;
         upper_ff <= 16'd0;
         held_ff  <= 8'd0;
         seg_ff   <= 16'd0;
         known_ff <= 1'b0;
         low_ff   <= 1'b0;
      end else if (step_en) begin
         pos_ff   <= pos_in;
         ip_ff    <= ip_in;
         upper_ff <= upper_in;
         held_ff  <= held_in;
         seg_ff   <= seg_in;
         known_ff <= known_in;
         low_ff   <= low_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_en && step.frame_end |=> pos_ff == 16'd0 && !known_ff && ip_ff == 16'd0)
      else $error("frame state not cleared after last byte");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      step_en && !step.frame_end && pos_ff == PosMax |=> pos_ff == PosMax)
      else $error("byte position wrapped");

   a_low_needs_known: assert property (@(posedge clock) disable iff (reset)
      low_ff |-> known_ff && seg_ff == 16'd0)
      else $error("length flagged low without a known zero segment length");

endmodule

>>> tb/ipv4_frame_checksum_checker.sv
// checker for the ipv4 frame checksum: watches both channels, predicts each result and compares
`timescale 1ns / 1ps

module ipv4_frame_checksum_checker
   import ipv4fc_pkg::*;
#(
   parameter int LINK_HEADER_BYTES = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,     // frame_byte
   input  logic        req_tlast,     // frame_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,     // ip_header_sum [15:0], upper_layer_sum [31:16]
   input  logic [1:0]  rsp_tuser,     // frame_short [0], length_bad [1]
   output int          fail_count,
   output int          outstanding
);

   // model of the block, updated at the clock edge of each transaction
   logic [7:0]  protocol = ProtocolReset;
   logic [15:0] byte_count = '0;
   logic [15:0] header_sum = '0;
   logic [15:0] segment_sum = '0;
   logic [15:0] seg_bytes = '0;
   logic [7:0]  high_byte = '0;
   logic        length_seen = 1'b0;
   logic        length_under = 1'b0;
   int          failures = 0;
   result_type  sums_due[$];

   function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      t = {1'b0, t[15:0]} + {16'd0, t[16]};
      return t[15:0];
   endfunction

   task automatic clear_frame();
      byte_count   = '0;
      header_sum   = '0;
      segment_sum  = '0;
      seg_bytes    = '0;
      high_byte    = '0;
      length_seen  = 1'b0;
      length_under = 1'b0;
   endtask

   // r is the offset from the start of the ip header
   task automatic fold_byte(input logic [7:0] b, input int r);
      logic [15:0] word;
      word = {high_byte, b};
      if (r % 2 == 0) begin
         high_byte = b;
         // odd final segment byte, padded with a zero low byte
         if (length_seen && r >= int'(IpHeaderBytes) && seg_bytes != 0 &&
             r - int'(IpHeaderBytes) == int'(seg_bytes) - 1)
            segment_sum = ones_sum(segment_sum, {b, 8'h00});
      end else if (r < int'(IpHeaderBytes)) begin
         header_sum = ones_sum(header_sum, word);
         if (r >= int'(AddrOffset))
            segment_sum = ones_sum(segment_sum, word);
         if (r == int'(LenLowOffset)) begin
            length_seen  = 1'b1;
            length_under = word < IpHeaderBytes;
            seg_bytes    = length_under ? 16'd0 : word - IpHeaderBytes;
         end
      end else if (length_seen && r - int'(IpHeaderBytes) < int'(seg_bytes)) begin
         segment_sum = ones_sum(segment_sum, word);
      end
   endtask

   task automatic take_frame_byte(input logic [7:0] b, input logic last);
      int         pos;
      int         have;
      int         need;
      logic [15:0] upper;
      result_type sums;
      pos = int'(byte_count);
      if (byte_count != PosMax && pos >= LINK_HEADER_BYTES)
         fold_byte(b, pos - LINK_HEADER_BYTES);
      if (byte_count != PosMax)
         byte_count = byte_count + 16'd1;
      if (last) begin
         have  = (pos == int'(PosMax)) ? int'(PosMax) : pos + 1;
         need  = LINK_HEADER_BYTES + int'(IpHeaderBytes) + int'(seg_bytes);
         upper = ones_sum(segment_sum, ones_sum(seg_bytes, {8'd0, protocol}));
         sums.ip_header_sum   = (header_sum == 16'd0) ? ZeroSumCode : header_sum;
         sums.upper_layer_sum = (upper == 16'd0) ? ZeroSumCode : upper;
         sums.frame_short     = !length_seen || have < need;
         sums.length_bad      = length_under;
         sums_due.push_back(sums);
         clear_frame();
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         protocol = ProtocolReset;
         clear_frame();
         sums_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sums_due.size() == 0) begin
               $display("%0t: result with no frame pending, expected none, actual %h %h",
                        $time, rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = sums_due.pop_front();
               check_field("ip_header_sum", want.ip_header_sum, rsp_tdata[15:0]);
               check_field("upper_layer_sum", want.upper_layer_sum, rsp_tdata[31:16]);
               check_field("frame_short", {15'd0, want.frame_short}, {15'd0, rsp_tuser[0]});
               check_field("length_bad", {15'd0, want.length_bad}, {15'd0, rsp_tuser[1]});
            end
         end
         if (req_tvalid && req_tready)
            take_frame_byte(req_tdata, req_tlast);
         if (csr_wr_en)
            protocol = csr_wr_data;
      end
      fail_count  <= failures;
      outstanding <= sums_due.size();
   end

endmodule

>>> tb/tb_ipv4_frame_checksum.sv
// testbench top for the ipv4 frame checksum: clock, reset, frame stimulus and verdict
`timescale 1ns / 1ps

module tb_ipv4_frame_checksum;
   import ipv4fc_pkg::*;

   localparam int LinkBytes    = 14;
   localparam int IpBytes      = 20;
   localparam int SettleCycles = 4;
   localparam int PhaseBytes   = 420;
   localparam int PhaseFrames  = 7;

   typedef enum {FillRandom, FillZero, FillOnes} fill_type;
   typedef enum {ReadyAlways, ReadyCoin, ReadySparse} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // frame_byte
   logic        req_tlast = 1'b0;   // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // ip_header_sum [15:0], upper_layer_sum [31:16]
   logic [1:0]  rsp_tuser;          // frame_short [0], length_bad [1]

   int             fail_count;
   int             outstanding;
   int             burst_left = 0;
   int             phase_bytes;
   int             phase_frames;
   stall_mode_type stall_mode = ReadyAlways;
   int             stall_timer = 0;
   logic [7:0]     frame_q[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ipv4_frame_checksum #(.LINK_HEADER_BYTES(LinkBytes)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   ipv4_frame_checksum_checker #(.LINK_HEADER_BYTES(LinkBytes)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // result side backpressure, switching between its own patterns
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= stall_mode_type'($urandom_range(0, 2));
         stall_timer <= $urandom_range(20, 300);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         ReadyAlways: rsp_tready <= 1'b1;
         ReadyCoin:   rsp_tready <= 1'($urandom_range(0, 1));
         default:     rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      int   gap;
      logic ready_seen;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 32);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      // sample ready mid-cycle so the accepting edge is known without a race
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      burst_left--;
   endtask

   // total_len lands in the ip total length field when the frame reaches it
   task automatic send_frame(input logic [15:0] total_len, input int frame_len,
                             input fill_type fill);
      frame_q.delete();
      for (int i = 0; i < frame_len; i++) begin
         if (i == LinkBytes + 2)
            frame_q.push_back(total_len[15:8]);
         else if (i == LinkBytes + 3)
            frame_q.push_back(total_len[7:0]);
         else if (fill == FillZero)
            frame_q.push_back(8'h00);
         else if (fill == FillOnes)
            frame_q.push_back(8'hFF);
         else
            frame_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (frame_q[i])
         push_byte(frame_q[i], i == frame_q.size() - 1);
      phase_bytes += frame_len;
      phase_frames++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_protocol(input logic [7:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_frame();
      int       seg;
      int       kind;
      int       total;
      int       flen;
      fill_type fill;
      kind  = $urandom_range(0, 9);
      seg   = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(0, 48);
      total = IpBytes + seg;
      flen  = LinkBytes + IpBytes + seg;
      fill  = ($urandom_range(0, 15) == 0) ? fill_type'($urandom_range(1, 2)) : FillRandom;
      if (kind < 6) begin
         // well formed, sometimes with padding after the segment
         if ($urandom_range(0, 3) == 0)
            flen += $urandom_range(1, 8);
      end else if (kind == 6) begin
         flen = $urandom_range(1, flen - 1);
      end else if (kind == 7) begin
         total = $urandom_range(0, IpBytes - 1);
         flen  = $urandom_range(1, 60);
      end else if (kind == 8) begin
         total = $urandom_range(0, 65535);
         flen  = $urandom_range(1, 100);
      end else begin
         flen = $urandom_range(1, LinkBytes + IpBytes);
      end
      send_frame(total[15:0], flen, fill);
   endtask

   task automatic random_phase();
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < PhaseBytes || phase_frames < PhaseFrames) begin
         send_random_frame();
         if ($urandom_range(0, 9) == 0)
            wait_idle();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short frames that end before or inside the ip header
      send_frame(16'd20, 1, FillRandom);
      send_frame(16'd40, LinkBytes + 3, FillRandom);
      send_frame(16'd40, LinkBytes + 11, FillRandom);
      // header extremes and bad total lengths
      send_frame(16'd20, LinkBytes + IpBytes, FillZero);
      send_frame(16'd0, 40, FillRandom);
      send_frame(16'd19, LinkBytes + IpBytes, FillOnes);
      // odd segment, trailing bytes, segment cut short
      send_frame(16'd21, LinkBytes + IpBytes + 1, FillRandom);
      send_frame(16'd29, LinkBytes + IpBytes + 14, FillRandom);
      send_frame(16'd30, LinkBytes + IpBytes + 7, FillRandom);

      // both sums come out zero
      write_protocol(8'd0);
      send_frame(16'd20, 1, FillZero);

      // length plus protocol wraps with end-around carry
      write_protocol(8'd255);
      send_frame(16'hFFFF, 40, FillOnes);

      // tcp protocol with an even segment and trailing bytes
      write_protocol(8'd6);
      send_frame(16'd48, LinkBytes + IpBytes + 31, FillRandom);

      random_phase();
      write_protocol(8'($urandom_range(0, 255)));
      random_phase();
      write_protocol(ProtocolReset);
      random_phase();

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("ipv4_frame_checksum regression: pass");
      else
         $display("ipv4_frame_checksum regression: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ipv4_frame_checksum regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/ipv4fc_pkg.sv
rtl/core/ipv4fc_accum.sv
rtl/core/ipv4_frame_checksum.sv
tb/ipv4_frame_checksum_checker.sv
tb/tb_ipv4_frame_checksum.sv
